>>> sv/lrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrm_pkg
// Shared widths, codes and the result record of the residency manager.
// ----------------------------------------------------------------------------
package lrm_pkg;

	localparam int LRM_MAX_LAYERS = 32;
	localparam int LRM_SIZE_BITS  = 48;

	localparam int KEY_W  = 16;
	localparam int ADDR_W = 64;
	localparam int VRAM_W = 48;
	localparam int SYS_W  = 53;
	localparam int STAT_W = 3;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
	localparam logic [OP_W-1:0] OP_RESIDENT = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;
	localparam logic [OP_W-1:0] OP_FREE     = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
	localparam logic [STAT_W-1:0] ST_LOADED    = 3'd1;
	localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_FIT    = 3'd3;
	localparam logic [STAT_W-1:0] ST_REFUSED   = 3'd4;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;
	localparam logic [STAT_W-1:0] ST_NOT_ALL   = 3'd6;

	localparam logic KIND_NOTICE = 1'b0;
	localparam logic KIND_ANSWER = 1'b1;

	typedef struct packed {
		logic                valid;
		logic                kind;
		logic [STAT_W-1:0]   status;
		logic [KEY_W-1:0]    evicted_key;
		logic [ADDR_W-1:0]   answer_address;
		logic [VRAM_W-1:0]   vram_bytes_used;
		logic [SYS_W-1:0]    system_bytes_used;
		logic                last;
	} lrm_result_t;

endpackage

>>> sv/lru_residency_manager_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_residency_manager_core
// Byte-budgeted least-recently-used residency table with stream ports.
// ----------------------------------------------------------------------------
// Register: non-final items only add to the running size, no result; a final
//   item passes through S_REG and S_EMIT into the output register. Queries and
//   free requests are bounded by the key scan over the entries.
// Make-resident: scan plus, per eviction, one pass over the recency list and its
//   notice, and a final recency pass if loaded or resident; one item at a time.
// Results wait in a one-deep output register until taken; one result per cycle max.
// Reset clears counts, byte totals and the budget; memories are not cleared.
module lru_residency_manager_core import lrm_pkg::*; #(
	parameter int MAX_LAYERS = LRM_MAX_LAYERS,
	parameter int SIZE_BITS  = LRM_SIZE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// [15:0] layer_key, [63:16] tensor_bytes, [127:64] granted_address,
	// [128] grant_ok, [135:129] zero
	input  logic [135:0]  s_axis_tdata,
	// [1:0] operation
	input  logic [1:0]    s_axis_tuser,
	input  logic          s_axis_tlast,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// [2:0] status, [18:3] evicted_key, [82:19] answer_address,
	// [130:83] vram_bytes_used, [183:131] system_bytes_used
	output logic [183:0]  m_axis_tdata,
	// [0] result_kind
	output logic          m_axis_tuser,
	output logic          m_axis_tlast,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [47:0]   cfg_data
);

	logic [SIZE_BITS-1:0] budget_q;
	logic                 idle;
	logic                 out_free;
	logic                 start;
	lrm_result_t          res;

	logic                 out_valid_q;
	logic [183:0]         out_data_q;
	logic                 out_kind_q;
	logic                 out_last_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = idle;
	assign start         = s_axis_tvalid && idle;
	assign out_free      = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (cfg_valid) begin
			budget_q <= SIZE_BITS'(cfg_data);
		end
	end

	lrm_ctrl #(.MAX_LAYERS(MAX_LAYERS), .SIZE_BITS(SIZE_BITS)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (s_axis_tuser),
		.key         (s_axis_tdata[15:0]),
		.bytes       (SIZE_BITS'(s_axis_tdata[63:16])),
		.last_tensor (s_axis_tlast),
		.grant       (s_axis_tdata[127:64]),
		.grant_ok    (s_axis_tdata[128]),
		.budget      (budget_q),
		.res_free    (out_free),
		.idle        (idle),
		.res         (res)
	);

	// hold the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			out_data_q <= {res.system_bytes_used, res.vram_bytes_used,
				res.answer_address, res.evicted_key, res.status};
			out_kind_q <= res.kind;
			out_last_q <= res.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

>>> sv/lrm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrm_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module lrm_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 2,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/lrm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrm_ctrl
// Sequencer over the entry table and the recency list memories.
// ----------------------------------------------------------------------------
module lrm_ctrl import lrm_pkg::*; #(
	parameter int MAX_LAYERS = LRM_MAX_LAYERS,
	parameter int SIZE_BITS  = LRM_SIZE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [OP_W-1:0]      op,
	input  logic [KEY_W-1:0]     key,
	input  logic [SIZE_BITS-1:0] bytes,
	input  logic                 last_tensor,
	input  logic [ADDR_W-1:0]    grant,
	input  logic                 grant_ok,
	input  logic [SIZE_BITS-1:0] budget,
	input  logic                 res_free,
	output logic                 idle,
	output lrm_result_t          res
);

	localparam int IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int CNT_W = $clog2(MAX_LAYERS + 1);
	localparam int ENT_W = KEY_W + SIZE_BITS + 1 + ADDR_W;
	localparam int SUM_W = ((SIZE_BITS > SYS_W) ? SIZE_BITS : SYS_W) + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LAYERS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_REG   = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_LOOK  = 4'd3;
	localparam logic [3:0] S_RSCAN = 4'd4;
	localparam logic [3:0] S_EVCHK = 4'd5;
	localparam logic [3:0] S_EVRD  = 4'd6;
	localparam logic [3:0] S_EVDAT = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;

	logic [3:0] state_q;

	logic [OP_W-1:0]      op_q;
	logic [KEY_W-1:0]     key_q;
	logic [ADDR_W-1:0]    grant_q;
	logic                 ok_q;
	logic [SIZE_BITS-1:0] tsum_q;
	logic [SYS_W-1:0]     sys_q;
	logic [SIZE_BITS-1:0] vram_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     rlen_q;
	logic [CNT_W-1:0]     n_q;
	logic                 stop_q;
	logic                 found_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SIZE_BITS-1:0] csize_q;
	logic                 cres_q;
	logic [ADDR_W-1:0]    caddr_q;
	logic [KEY_W-1:0]     ckey_q;
	logic [IDX_W-1:0]     victim_q;
	logic                 rmode_q;
	logic [CNT_W-1:0]     rptr_q;
	logic                 rdv_s1;
	logic [CNT_W-1:0]     rtag_s1;
	logic                 rfound_q;
	logic [CNT_W-1:0]     sptr_q;
	logic                 sdv_s1;
	logic [CNT_W-1:0]     stag_s1;

	logic                 e_kind_q;
	logic [STAT_W-1:0]    e_status_q;
	logic [KEY_W-1:0]     e_key_q;
	logic [ADDR_W-1:0]    e_addr_q;
	logic                 e_last_q;

	// entry memory
	logic             ent_we;
	logic [IDX_W-1:0] ent_waddr;
	logic [ENT_W-1:0] ent_wdata;
	logic [IDX_W-1:0] ent_raddr;
	logic [ENT_W-1:0] ent_rdata;

	// recency memory
	logic             rec_we;
	logic [IDX_W-1:0] rec_waddr;
	logic [IDX_W-1:0] rec_wdata;
	logic [IDX_W-1:0] rec_raddr;
	logic [IDX_W-1:0] rec_rdata;

	lrm_ram #(.W(ENT_W), .DEPTH(MAX_LAYERS)) u_entries (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	lrm_ram #(.W(IDX_W), .DEPTH(MAX_LAYERS)) u_recency (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	// entry word: {address, resident, size, key}
	logic [KEY_W-1:0]     r_key;
	logic [SIZE_BITS-1:0] r_size;
	logic                 r_res;
	logic [ADDR_W-1:0]    r_addr;
	assign r_key  = ent_rdata[KEY_W-1:0];
	assign r_size = ent_rdata[KEY_W +: SIZE_BITS];
	assign r_res  = ent_rdata[KEY_W + SIZE_BITS];
	assign r_addr = ent_rdata[ENT_W-1 -: ADDR_W];

	logic [SIZE_BITS:0]   tsum_w;
	logic [SIZE_BITS-1:0] tsum_next;
	logic [SUM_W-1:0]     sys_sum;
	logic [SYS_W-1:0]     sys_next;
	logic [SIZE_BITS:0]   need;
	logic                 fits;
	logic                 s_issue;
	logic                 s_match;
	logic                 r_issue;
	logic                 r_match;
	logic                 evict_go;

	assign tsum_w    = {1'b0, tsum_q} + {1'b0, bytes};
	assign tsum_next = tsum_w[SIZE_BITS] ? {SIZE_BITS{1'b1}} : tsum_w[SIZE_BITS-1:0];
	assign sys_sum   = SUM_W'(sys_q) + SUM_W'(tsum_q);
	assign sys_next  = (sys_sum[SUM_W-1:SYS_W] != '0) ? {SYS_W{1'b1}} : sys_sum[SYS_W-1:0];
	assign need      = {1'b0, vram_q} + {1'b0, csize_q};
	assign fits      = need <= {1'b0, budget};
	assign evict_go  = !fits && !stop_q && (rlen_q != '0) && (n_q < CNT_MAX);

	assign s_issue = sptr_q < count_q;
	assign s_match = (op_q == OP_FREE) ? !r_res : (r_key == key_q);
	assign r_issue = rptr_q < rlen_q;
	assign r_match = rmode_q ? (rtag_s1 == '0) : (rec_rdata == idx_q);

	assign idle = (state_q == S_IDLE);

	function automatic logic [IDX_W-1:0] rtag_tail(input logic [CNT_W-1:0] len);
		logic [CNT_W-1:0] t;
		t = len - CNT_W'(1);
		return t[IDX_W-1:0];
	endfunction

	always_comb begin
		res                   = '0;
		res.valid             = (state_q == S_EMIT);
		res.kind              = e_kind_q;
		res.status            = e_status_q;
		res.evicted_key       = e_key_q;
		res.answer_address    = e_addr_q;
		res.vram_bytes_used   = VRAM_W'(vram_q);
		res.system_bytes_used = sys_q;
		res.last              = e_last_q;
	end

	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = idx_q;
		ent_wdata = {caddr_q, cres_q, csize_q, ckey_q};
		ent_raddr = (state_q == S_EVRD) ? victim_q : sptr_q[IDX_W-1:0];
		rec_we    = 1'b0;
		rec_waddr = rtag_s1[IDX_W-1:0] - IDX_W'(1);
		rec_wdata = rec_rdata;
		rec_raddr = rptr_q[IDX_W-1:0];
		unique case (state_q)
			S_REG: begin
				ent_we    = count_q < CNT_MAX;
				ent_waddr = count_q[IDX_W-1:0];
				ent_wdata = {{ADDR_W{1'b0}}, 1'b0, tsum_q, key_q};
			end
			S_EVCHK: begin
				ent_we    = fits && ok_q;
				ent_wdata = {grant_q, 1'b1, csize_q, ckey_q};
			end
			S_EVDAT: begin
				ent_we    = (CNT_W'(victim_q) < count_q) && r_res;
				ent_waddr = victim_q;
				ent_wdata = {r_addr, 1'b0, r_size, r_key};
			end
			S_RSCAN: begin
				if (rdv_s1) begin
					// close the gap left by the removed position
					rec_we = rfound_q;
				end else if (!r_issue && !rmode_q) begin
					rec_we    = rfound_q || (rlen_q < CNT_MAX);
					rec_waddr = rfound_q ? rtag_tail(rlen_q) : rlen_q[IDX_W-1:0];
					rec_wdata = idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			tsum_q   <= '0;
			sys_q    <= '0;
			vram_q   <= '0;
			count_q  <= '0;
			rlen_q   <= '0;
			rdv_s1   <= 1'b0;
			sdv_s1   <= 1'b0;
			rfound_q <= 1'b0;
			found_q  <= 1'b0;
			stop_q   <= 1'b0;
			n_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						key_q   <= key;
						grant_q <= grant;
						ok_q    <= grant_ok;
						sptr_q  <= '0;
						sdv_s1  <= 1'b0;
						if (op == OP_REGISTER) begin
							tsum_q <= tsum_next;
							if (last_tensor) begin
								state_q <= S_REG;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_REG: begin
					e_kind_q <= KIND_ANSWER;
					e_key_q  <= '0;
					e_addr_q <= '0;
					e_last_q <= 1'b1;
					tsum_q   <= '0;
					if (count_q < CNT_MAX) begin
						count_q    <= count_q + CNT_W'(1);
						sys_q      <= sys_next;
						e_status_q <= ST_DONE;
					end else begin
						e_status_q <= ST_FULL;
					end
					state_q <= S_EMIT;
				end
				S_SCAN: begin
					if (s_issue) begin
						sptr_q <= sptr_q + CNT_W'(1);
					end
					sdv_s1  <= s_issue;
					stag_s1 <= sptr_q;
					if (sdv_s1 && s_match) begin
						found_q <= 1'b1;
						idx_q   <= stag_s1[IDX_W-1:0];
						ckey_q  <= r_key;
						csize_q <= r_size;
						cres_q  <= r_res;
						caddr_q <= r_addr;
						state_q <= S_LOOK;
					end else if (!s_issue && !sdv_s1) begin
						found_q <= 1'b0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					e_kind_q <= KIND_ANSWER;
					e_key_q  <= '0;
					e_addr_q <= '0;
					e_last_q <= 1'b1;
					state_q  <= S_EMIT;
					priority if (op_q == OP_FREE) begin
						if (found_q) begin
							e_status_q <= ST_NOT_ALL;
						end else begin
							sys_q      <= '0;
							e_status_q <= ST_DONE;
						end
					end else if (!found_q) begin
						e_status_q <= ST_UNKNOWN;
					end else if (op_q == OP_QUERY) begin
						e_status_q <= ST_DONE;
						e_addr_q   <= cres_q ? caddr_q : '0;
					end else if (cres_q) begin
						e_status_q <= ST_DONE;
						e_addr_q   <= caddr_q;
						rmode_q    <= 1'b0;
						rptr_q     <= '0;
						rdv_s1     <= 1'b0;
						rfound_q   <= 1'b0;
						state_q    <= S_RSCAN;
					end else begin
						n_q     <= '0;
						stop_q  <= 1'b0;
						state_q <= S_EVCHK;
					end
				end
				S_EVCHK: begin
					e_key_q  <= '0;
					e_addr_q <= '0;
					e_kind_q <= KIND_ANSWER;
					e_last_q <= 1'b1;
					rptr_q   <= '0;
					rdv_s1   <= 1'b0;
					rfound_q <= 1'b0;
					priority if (evict_go) begin
						rmode_q <= 1'b1;
						state_q <= S_RSCAN;
					end else if (!fits) begin
						e_status_q <= ST_NO_FIT;
						state_q    <= S_EMIT;
					end else if (!ok_q) begin
						e_status_q <= ST_REFUSED;
						state_q    <= S_EMIT;
					end else begin
						vram_q     <= need[SIZE_BITS-1:0];
						e_status_q <= ST_LOADED;
						e_addr_q   <= grant_q;
						rmode_q    <= 1'b0;
						state_q    <= S_RSCAN;
					end
				end
				S_RSCAN: begin
					if (r_issue) begin
						rptr_q <= rptr_q + CNT_W'(1);
					end
					rdv_s1  <= r_issue;
					rtag_s1 <= rptr_q;
					if (rdv_s1) begin
						if (!rfound_q && r_match) begin
							rfound_q <= 1'b1;
							victim_q <= rec_rdata;
						end
					end else if (!r_issue) begin
						if (rmode_q) begin
							rlen_q  <= rlen_q - CNT_W'(1);
							state_q <= S_EVRD;
						end else begin
							if (!rfound_q && (rlen_q < CNT_MAX)) begin
								rlen_q <= rlen_q + CNT_W'(1);
							end
							state_q <= S_EMIT;
						end
					end
				end
				S_EVRD: begin
					state_q <= S_EVDAT;
				end
				S_EVDAT: begin
					if ((CNT_W'(victim_q) < count_q) && r_res) begin
						vram_q     <= (vram_q >= r_size) ? vram_q - r_size : '0;
						n_q        <= n_q + CNT_W'(1);
						e_kind_q   <= KIND_NOTICE;
						e_status_q <= ST_DONE;
						e_key_q    <= r_key;
						e_addr_q   <= '0;
						e_last_q   <= 1'b0;
						state_q    <= S_EMIT;
					end else begin
						stop_q  <= 1'b1;
						state_q <= S_EVCHK;
					end
				end
				S_EMIT: begin
					if (res_free) begin
						state_q <= e_last_q ? S_IDLE : S_EVCHK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("entry count beyond table depth");

	a_recency_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rlen_q <= count_q)
		else $error("recency list longer than entry table");

	a_evict_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_MAX)
		else $error("eviction count beyond table depth");

	a_notice_loops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && res_free && !e_last_q) |=> state_q == S_EVCHK)
		else $error("eviction notice not followed by budget check");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && idle && op != OP_REGISTER) |=> !idle)
		else $error("request dropped on acceptance");

endmodule
